### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk_i.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define SSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every edge, reset included
`define SSS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### design/sss_pkg.sv
// ----------------------------------------------------------------------------
// sss_pkg
// Shared constants and types of the substring search core.
// ----------------------------------------------------------------------------
package sss_pkg;

  localparam int MAX_NEEDLE   = 16;
  localparam int NEEDLE_BYTES = 16;
  localparam int CMP_LEN      = (MAX_NEEDLE < NEEDLE_BYTES) ? MAX_NEEDLE : NEEDLE_BYTES;
  localparam int LEN_W        = 5;
  localparam int EFF_W        = $clog2(CMP_LEN + 1);
  localparam int CNT_W        = 32;
  localparam int CFG_W        = 64;
  localparam int CFG_IDX_W    = 2;
  localparam int IN_DATA_W    = 8;
  localparam int OUT_DATA_W   = 40;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NEEDLE_LOW  = 2'd0,
    CFG_NEEDLE_HIGH = 2'd1,
    CFG_NEEDLE_LEN  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [CMP_LEN-1:0][7:0] bytes;
    logic [EFF_W-1:0]        len;
  } needle_cfg_t;

endpackage

### design/sss_cfg_regs.sv
// ----------------------------------------------------------------------------
// sss_cfg_regs
// Needle registers; presents the needle bytes and the capped length.
// ----------------------------------------------------------------------------
module sss_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sss_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [sss_pkg::CFG_W-1:0]     cfg_wdata_i,
  output sss_pkg::needle_cfg_t          needle_o
);
  import sss_pkg::*;

  logic [CFG_W-1:0]          low_q, high_q;
  logic [LEN_W-1:0]          len_q;
  logic [2*CFG_W-1:0]        all_bytes;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= '0;
      high_q <= '0;
      len_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_NEEDLE_LOW:  low_q  <= cfg_wdata_i;
        CFG_NEEDLE_HIGH: high_q <= cfg_wdata_i;
        CFG_NEEDLE_LEN:  len_q  <= cfg_wdata_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign all_bytes = {high_q, low_q};

  always_comb begin
    for (int i = 0; i < CMP_LEN; i++) begin
      needle_o.bytes[i] = all_bytes[8*i +: 8];
    end
    if (len_q > LEN_W'(CMP_LEN)) begin
      needle_o.len = EFF_W'(CMP_LEN);
    end else begin
      needle_o.len = EFF_W'(len_q);
    end
  end

endmodule

### design/sss_window.sv
// ----------------------------------------------------------------------------
// sss_window
// Shift window of recent bytes and parallel compare against the needle.
// ----------------------------------------------------------------------------
module sss_window (
  input  logic                 clk_i,
  input  logic                 shift_i,
  input  logic [7:0]           byte_i,
  input  sss_pkg::needle_cfg_t needle_i,
  output logic                 hit_o
);
  import sss_pkg::*;

  logic [MAX_NEEDLE-1:0][7:0] win_q;
  logic [MAX_NEEDLE-1:0][7:0] win_d;
  logic [CMP_LEN:0]           hit_len;

  // entry 0 is the newest byte
  always_comb begin
    win_d[0] = byte_i;
    for (int j = 1; j < MAX_NEEDLE; j++) begin
      win_d[j] = win_q[j-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      win_q <= win_d;
    end
  end

  // hit_len[l]: the newest l bytes equal needle bytes 0..l-1
  always_comb begin
    hit_len = '0;
    for (int l = 1; l <= CMP_LEN; l++) begin
      hit_len[l] = 1'b1;
      for (int i = 0; i < l; i++) begin
        if (win_d[l-1-i] != needle_i.bytes[i]) begin
          hit_len[l] = 1'b0;
        end
      end
    end
  end

  assign hit_o = hit_len[needle_i.len];

endmodule

### design/substring_search_core.sv
// ----------------------------------------------------------------------------
// substring_search_core
// Streaming first-occurrence search of a needle of up to 16 bytes.
// ----------------------------------------------------------------------------
// Haystack bytes enter one per cycle; each byte is compared in the same cycle
// against the needle over a 16-byte window, and the input accepts a byte
// every clock as long as the result register is free or being drained. The
// byte flagged tlast yields one result (found, start offset
// of the first match, offset 0 when not found) and clears the search for the
// next haystack. The byte counter saturates at 0xFFFFFFFF. Needle length 0
// matches at offset 0; lengths above 16 are taken as 16. Write the needle
// registers only while no haystack is in flight.
module substring_search_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sss_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sss_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [sss_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // [7:0] hay_byte
  input  logic                           s_axis_tlast,   // last_byte
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [sss_pkg::OUT_DATA_W-1:0] m_axis_tdata    // [0] found, [32:1] match_offset
);
  import sss_pkg::*;

  needle_cfg_t      needle;
  logic             accept, hit;
  logic [CNT_W-1:0] cnt_q, cnt_d, cnt_next;
  logic             seen_q, seen_d, seen_next;
  logic [CNT_W-1:0] off_q, off_d, off_next;
  logic             out_valid_q, out_valid_d;
  logic             found_q, found_d;
  logic [CNT_W-1:0] res_off_q, res_off_d;

  sss_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .needle_o    (needle)
  );

  sss_window u_win (
    .clk_i    (clk_i),
    .shift_i  (accept),
    .byte_i   (s_axis_tdata[7:0]),
    .needle_i (needle),
    .hit_o    (hit)
  );

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    cnt_next  = (cnt_q == '1) ? cnt_q : cnt_q + CNT_W'(1);
    seen_next = seen_q;
    off_next  = off_q;
    if (!seen_q) begin
      if (needle.len == '0) begin
        seen_next = 1'b1;
        off_next  = '0;
      end else if (cnt_next >= CNT_W'(needle.len) && hit) begin
        seen_next = 1'b1;
        off_next  = cnt_next - CNT_W'(needle.len);
      end
    end

    cnt_d       = cnt_q;
    seen_d      = seen_q;
    off_d       = off_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    found_d     = found_q;
    res_off_d   = res_off_q;
    if (accept) begin
      if (s_axis_tlast) begin
        cnt_d       = '0;
        seen_d      = 1'b0;
        off_d       = '0;
        out_valid_d = 1'b1;
        found_d     = seen_next;
        res_off_d   = seen_next ? off_next : '0;
      end else begin
        cnt_d  = cnt_next;
        seen_d = seen_next;
        off_d  = off_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      seen_q      <= 1'b0;
      off_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      seen_q      <= seen_d;
      off_q       <= off_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    found_q   <= found_d;
    res_off_q <= res_off_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OUT_DATA_W - CNT_W - 1)'(0), res_off_q, found_q};

endmodule

### design/sss_checker.sv
// ----------------------------------------------------------------------------
// sss_checker
// Port-level checks of the substring search core, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sss_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           s_axis_tlast,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [sss_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import sss_pkg::*;

  `SSS_ASSERT_ALWAYS(a_no_out_in_reset, !rst_ni |-> !m_axis_tvalid, "result valid in reset")

  `SSS_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

  `SSS_ASSERT(a_out_after_last, $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast), "result without last byte")

  `SSS_ASSERT(a_no_take_when_full, m_axis_tvalid && !m_axis_tready |-> !s_axis_tready, "input taken over stalled result")

  `SSS_ASSERT(a_miss_zero_offset, m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[CNT_W:1] == '0, "miss with nonzero offset")

endmodule

bind substring_search_core sss_checker u_sss_checker (.*);

### tb/substring_search_checker.sv
// ----------------------------------------------------------------------------
// substring_search_checker
// Watches the needle register writes and both stream channels of the
// substring search core, keeps its own model of the search window, predicts
// the verdict of every haystack and compares each result transaction with it.
// ----------------------------------------------------------------------------
module substring_search_checker
  import sss_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                  s_axis_tlast,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,
  output int unsigned           pending_o,
  output int unsigned           errors_o,
  output int unsigned           bytes_o,
  output int unsigned           results_o,
  output int unsigned           hits_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        found;
    logic [31:0] offset;
  } verdict_t;

  logic [7:0]  hay_window [MAX_NEEDLE];
  logic [31:0] hay_count;
  logic        hit_seen;
  logic [31:0] hit_offset;
  logic [63:0] ndl_low;
  logic [63:0] ndl_high;
  logic [4:0]  ndl_len;
  verdict_t    verdict_q [$];
  int unsigned fails, n_bytes, n_results, n_hits;

  function automatic logic [7:0] needle_at(int unsigned i);
    return (i < 8) ? ndl_low[i*8 +: 8] : ndl_high[(i-8)*8 +: 8];
  endfunction

  function automatic int unsigned match_len();
    int unsigned n;
    n = ndl_len;
    if (n > 16) n = 16;
    if (n > MAX_NEEDLE) n = MAX_NEEDLE;
    return n;
  endfunction

  task automatic clear_search();
    int j;
    for (j = 0; j < MAX_NEEDLE; j++) hay_window[j] = 8'h00;
    hay_count  = '0;
    hit_seen   = 1'b0;
    hit_offset = '0;
  endtask

  // shift one haystack byte in; on the last byte queue the verdict
  task automatic scan_byte(input logic [7:0] b, input logic is_last);
    int unsigned n;
    int          j;
    logic        hit;
    verdict_t    v;
    n = match_len();
    for (j = MAX_NEEDLE - 1; j > 0; j--) hay_window[j] = hay_window[j-1];
    hay_window[0] = b;
    if (hay_count != 32'hFFFF_FFFF) hay_count++;
    if (!hit_seen) begin
      hit = (hay_count >= n);
      for (j = 0; j < n; j++) begin
        if (hay_window[n-1-j] != needle_at(j)) hit = 1'b0;
      end
      if (hit) begin
        hit_seen   = 1'b1;
        hit_offset = (n == 0) ? 32'd0 : hay_count - n;
      end
    end
    if (is_last) begin
      v.found  = hit_seen;
      v.offset = hit_seen ? hit_offset : 32'd0;
      verdict_q.push_back(v);
      clear_search();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t want;
    logic     bad;
    if (!rst_ni) begin
      clear_search();
      ndl_low   = '0;
      ndl_high  = '0;
      ndl_len   = '0;
      verdict_q.delete();
      fails     = 0;
      n_bytes   = 0;
      n_results = 0;
      n_hits    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_NEEDLE_LOW:  ndl_low  = cfg_wdata_i;
          CFG_NEEDLE_HIGH: ndl_high = cfg_wdata_i;
          CFG_NEEDLE_LEN:  ndl_len  = cfg_wdata_i[4:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: result with nothing expected, tdata=%h", $time, m_axis_tdata);
          fails++;
        end else begin
          want = verdict_q.pop_front();
          bad  = 1'b0;
          if (m_axis_tdata[0] !== want.found) begin
            $display("%0t: found expected %0d actual %0d",
                     $time, want.found, m_axis_tdata[0]);
            bad = 1'b1;
          end
          if (m_axis_tdata[32:1] !== want.offset) begin
            $display("%0t: match_offset expected %0d actual %0d",
                     $time, want.offset, m_axis_tdata[32:1]);
            bad = 1'b1;
          end
          if (m_axis_tdata[OUT_DATA_W-1:33] !== '0) begin
            $display("%0t: tdata padding expected 0 actual %h",
                     $time, m_axis_tdata[OUT_DATA_W-1:33]);
            bad = 1'b1;
          end
          if (bad) fails++;
          n_results++;
          if (want.found) n_hits++;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        scan_byte(s_axis_tdata, s_axis_tlast);
        n_bytes++;
      end
    end
    pending_o <= verdict_q.size();
    errors_o  <= fails;
    bytes_o   <= n_bytes;
    results_o <= n_results;
    hits_o    <= n_hits;
  end

endmodule

### tb/tb_substring_search_core.sv
// ----------------------------------------------------------------------------
// tb_substring_search_core
// Drives haystacks and needle settings into the substring search core: a
// directed set of corner cases (empty, single byte, short haystack, capped
// length, full 16-byte needle), then random needles over small alphabets
// with planted matches, random gaps on input and random output stalls.
// The checker beside the block predicts and compares every verdict.
// ----------------------------------------------------------------------------
module tb_substring_search_core;
  timeunit 1ns;
  timeprecision 1ps;
  import sss_pkg::*;

  localparam int STUCK_LIMIT = 2000;

  logic                  clk_i;
  logic                  rst_ni        = 1'b1;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_W-1:0]      cfg_wdata_i   = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  s_axis_tlast  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  int unsigned pending, errors, n_bytes, n_results, n_hits;
  int unsigned items    = 0;
  int unsigned settings = 0;
  int unsigned stuck    = 0;
  bit          calm     = 1'b0;

  substring_search_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),    // [7:0] hay_byte
    .s_axis_tlast  (s_axis_tlast),    // last_byte
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)     // [0] found, [32:1] match_offset
  );

  substring_search_checker search_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .pending_o     (pending),
    .errors_o      (errors),
    .bytes_o       (n_bytes),
    .results_o     (n_results),
    .hits_o        (n_hits)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // mostly no gap, some short, a few long; none at all in calm phases
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result sink with random stalls
  initial begin
    int unsigned hold;
    forever begin
      hold = pick_gap();
      if (hold != 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
      stuck <= 0;
    else
      stuck <= stuck + 1;
    if (stuck >= STUCK_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STUCK_LIMIT);
      $display("tb_substring_search_core failed");
      $finish;
    end
  end

  task automatic write_needle(input logic [63:0] lo_w, input logic [63:0] hi_w,
                              input logic [63:0] len_w);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_NEEDLE_LOW;
    cfg_wdata_i <= lo_w;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_NEEDLE_HIGH;
    cfg_wdata_i <= hi_w;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_NEEDLE_LEN;
    cfg_wdata_i <= len_w;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    settings++;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic is_last);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= is_last;
    do @(posedge clk_i); while (!s_axis_tready);
    items++;
  endtask

  task automatic send_hay(input logic [7:0] hay [$]);
    int k;
    for (k = 0; k < hay.size(); k++) send_byte(hay[k], k == hay.size() - 1);
  endtask

  // hold the input until every verdict is back, then let the core settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic random_phase();
    logic [7:0]  sym0, sym1, nb;
    logic [7:0]  pat [16];
    logic [63:0] lo_w, hi_w, len_w;
    logic [7:0]  hay [$];
    int unsigned r, n, hay_len, at, k, h, hays;
    r = $urandom_range(0, 99);
    if (r < 5)       len_w = 64'd0;
    else if (r < 70) len_w = 64'($urandom_range(1, 6));
    else if (r < 88) len_w = 64'($urandom_range(7, 15));
    else if (r < 95) len_w = 64'd16;
    else             len_w = 64'($urandom_range(17, 31));
    n = (len_w > 64'd16) ? 32'd16 : 32'(len_w);
    if ($urandom_range(0, 1) == 1) len_w = ({$urandom, $urandom} & ~64'h1F) | len_w;
    sym0 = 8'($urandom_range(0, 255));
    sym1 = 8'($urandom_range(0, 255));
    for (k = 0; k < 16; k++) begin
      if ($urandom_range(0, 9) < 8) nb = ($urandom_range(0, 1) == 1) ? sym0 : sym1;
      else nb = 8'($urandom_range(0, 255));
      pat[k] = nb;
      if (k < 8) lo_w[k*8 +: 8] = nb;
      else hi_w[(k-8)*8 +: 8] = nb;
    end
    calm = ($urandom_range(0, 3) == 0);
    write_needle(lo_w, hi_w, len_w);
    hays = $urandom_range(3, 8);
    for (h = 0; h < hays; h++) begin
      hay_len = ($urandom_range(0, 9) < 9) ? $urandom_range(1, 24) : $urandom_range(25, 64);
      hay.delete();
      for (k = 0; k < hay_len; k++) begin
        r = $urandom_range(0, 9);
        if (r < 7) hay.push_back(r[0] ? sym0 : sym1);
        else hay.push_back(8'($urandom_range(0, 255)));
      end
      if (n != 0 && hay_len >= n && $urandom_range(0, 9) < 4) begin
        at = $urandom_range(0, hay_len - n);
        for (k = 0; k < n; k++) hay[at + k] = pat[k];
      end
      send_hay(hay);
    end
    drain();
    calm = 1'b0;
  endtask

  initial begin
    logic [7:0] hay [$];
    int         k;
    rst_ni <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty needle straight out of reset
    hay = '{8'hFF};
    send_hay(hay);
    drain();

    // single NUL byte needle
    write_needle(64'h0, 64'h0, 64'd1);
    hay = '{8'h41, 8'h00, 8'hFF};
    send_hay(hay);
    drain();

    // haystack shorter than the needle, then a hit at offset 1
    write_needle(64'h0000_0000_0063_6261, 64'hFFFF_FFFF_FFFF_FFFF, 64'd3);
    hay = '{8'h61, 8'h62};
    send_hay(hay);
    hay = '{8'h78, 8'h61, 8'h62, 8'h63};
    send_hay(hay);
    drain();

    // length 31 capped at 16, full window match
    write_needle(64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 64'd31);
    hay.delete();
    for (k = 0; k < 16; k++) hay.push_back((k < 8) ? 8'hFF : 8'h00);
    send_hay(hay);
    drain();

    while (items < 1050) random_phase();

    $display("Ran %0d haystack bytes under %0d needle settings", n_bytes, settings);
    $display("Checked %0d search results, %0d of them with a match", n_results, n_hits);
    if (errors == 0 && pending == 0) begin
      $display("tb_substring_search_core passed");
    end else begin
      $display("tb_substring_search_core failed");
    end
    $finish;
  end

endmodule
